// ----- hw/rtl/dtlr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtlr_pkg
// Shared types and constants for the dashed thick line rasterizer.
// ----------------------------------------------------------------------------
package dtlr_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int MAX_PEN_DEF    = 8;

  // dash pattern: three points on, three points off
  localparam int DASH_PERIOD = 6;
  localparam int DASH_ON     = 3;
  localparam int DASH_W      = 3;

  // request kinds carried on in_tuser
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  typedef enum logic {
    S_IDLE,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load_line;
    logic begin_step;
    logic next_pix;
    logic finish_step;
  } cmd_t;

  typedef struct packed {
    logic pix_last;
  } status_t;

endpackage

// ----- hw/rtl/dtlr_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtlr_ctrl
// Handshake controller: accepts requests, walks the result transactions and
// issues commands to the datapath.
// ----------------------------------------------------------------------------
module dtlr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              req_type,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  dtlr_pkg::status_t status,
  output dtlr_pkg::cmd_t    cmd
);
  import dtlr_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && (req_type == REQ_STEP)) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_tready && status.pix_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (req_type == REQ_START) begin
            cmd.load_line = 1'b1;
          end else begin
            cmd.begin_step = 1'b1;
          end
        end
      end
      S_EMIT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (status.pix_last) begin
            cmd.finish_step = 1'b1;
          end else begin
            cmd.next_pix = 1'b1;
          end
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- hw/rtl/dtlr_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtlr_datapath
// Line state, Bresenham stepping, dash phase and pen square walk, with the
// result payload held in output registers.
// ----------------------------------------------------------------------------
module dtlr_datapath #(
  parameter int COORD_BITS = dtlr_pkg::COORD_BITS_DEF,
  parameter int MAX_PEN    = dtlr_pkg::MAX_PEN_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dtlr_pkg::cmd_t        cmd,
  output dtlr_pkg::status_t     status,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  input  logic [1:0]            ink,
  input  logic [3:0]            pen_size,
  input  logic                  dashed,
  output logic [COORD_BITS:0]   pixel_x,
  output logic [COORD_BITS:0]   pixel_y,
  output logic [1:0]            pixel_ink,
  output logic                  write_enable,
  output logic                  pix_last,
  output logic                  line_done
);
  import dtlr_pkg::*;

  localparam int OFF_W = (MAX_PEN > 1) ? $clog2(MAX_PEN) : 1;
  localparam int ERR_W = COORD_BITS + 2;
  localparam int PIX_W = COORD_BITS + 1;

  // line state
  logic [COORD_BITS-1:0] cur_x_r, cur_y_r, goal_x_r, goal_y_r;
  logic [COORD_BITS-1:0] span_x_r, span_y_r;
  logic signed [ERR_W-1:0] err_r;
  logic                  step_x_neg_r, step_y_neg_r;
  logic [DASH_W-1:0]     dash_phase_r;
  logic [1:0]            line_ink_r;
  logic [OFF_W-1:0]      pen_m1_r;
  logic                  line_dashed_r;
  logic                  active_r;

  // per-step state
  logic                  step_live_r;
  logic                  at_end_r;
  logic [OFF_W-1:0]      dx_r, dy_r;

  // result registers
  logic [PIX_W-1:0]      out_x_r, out_y_r;
  logic [1:0]            out_ink_r;
  logic                  out_we_r, out_last_r, out_done_r;

  logic                  at_end;
  logic                  draw;
  logic [OFF_W-1:0]      pen_m1_in;
  logic [COORD_BITS-1:0] span_x_in, span_y_in;
  logic signed [ERR_W-1:0] err_in;
  logic [OFF_W-1:0]      dx_nxt, dy_nxt;
  logic                  last_nxt;
  logic signed [ERR_W:0] e2, sx_e, sy_e, e_a, e_b;
  logic                  mv_x, mv_y;
  logic signed [ERR_W-1:0] err_nxt;
  logic [DASH_W-1:0]     dash_nxt;

  assign at_end = (cur_x_r == goal_x_r) && (cur_y_r == goal_y_r);
  assign draw   = !line_dashed_r || (dash_phase_r < DASH_W'(DASH_ON));

  // pen size clamp to 1..MAX_PEN, kept as size minus one
  always_comb begin
    if (pen_size == 4'd0) begin
      pen_m1_in = '0;
    end else if (pen_size > 4'(MAX_PEN)) begin
      pen_m1_in = OFF_W'(MAX_PEN - 1);
    end else begin
      pen_m1_in = OFF_W'(pen_size - 4'd1);
    end
  end

  assign span_x_in = (end_x > start_x) ? (end_x - start_x) : (start_x - end_x);
  assign span_y_in = (end_y > start_y) ? (end_y - start_y) : (start_y - end_y);
  assign err_in    = signed'({2'b00, span_x_in}) - signed'({2'b00, span_y_in});

  // pen square walk, x fastest
  always_comb begin
    if (dx_r == pen_m1_r) begin
      dx_nxt = '0;
      dy_nxt = dy_r + OFF_W'(1);
    end else begin
      dx_nxt = dx_r + OFF_W'(1);
      dy_nxt = dy_r;
    end
  end
  assign last_nxt = (dx_nxt == pen_m1_r) && (dy_nxt == pen_m1_r);

  // one Bresenham step
  assign e2   = {err_r, 1'b0};
  assign sx_e = signed'({3'b000, span_x_r});
  assign sy_e = signed'({3'b000, span_y_r});
  assign mv_x = (e2 >= -sy_e);
  assign mv_y = (e2 <= sx_e);
  assign e_a  = {err_r[ERR_W-1], err_r} - (mv_x ? sy_e : '0);
  assign e_b  = e_a + (mv_y ? sx_e : '0);
  assign err_nxt = e_b[ERR_W-1:0];

  assign dash_nxt = (dash_phase_r >= DASH_W'(DASH_PERIOD - 1)) ? '0
                                                               : dash_phase_r + DASH_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r       <= '0;
      cur_y_r       <= '0;
      goal_x_r      <= '0;
      goal_y_r      <= '0;
      span_x_r      <= '0;
      span_y_r      <= '0;
      err_r         <= '0;
      step_x_neg_r  <= 1'b0;
      step_y_neg_r  <= 1'b0;
      dash_phase_r  <= '0;
      line_ink_r    <= '0;
      pen_m1_r      <= '0;
      line_dashed_r <= 1'b0;
      active_r      <= 1'b0;
      step_live_r   <= 1'b0;
      at_end_r      <= 1'b0;
      dx_r          <= '0;
      dy_r          <= '0;
    end else begin
      priority if (cmd.load_line) begin
        cur_x_r       <= start_x;
        cur_y_r       <= start_y;
        goal_x_r      <= end_x;
        goal_y_r      <= end_y;
        span_x_r      <= span_x_in;
        span_y_r      <= span_y_in;
        step_x_neg_r  <= !(start_x < end_x);
        step_y_neg_r  <= !(start_y < end_y);
        err_r         <= err_in;
        pen_m1_r      <= pen_m1_in;
        line_ink_r    <= ink;
        line_dashed_r <= dashed;
        dash_phase_r  <= '0;
        active_r      <= 1'b1;
      end else if (cmd.begin_step) begin
        step_live_r <= active_r;
        at_end_r    <= at_end;
        dx_r        <= '0;
        dy_r        <= '0;
      end else if (cmd.next_pix) begin
        dx_r <= dx_nxt;
        dy_r <= dy_nxt;
      end else if (cmd.finish_step) begin
        if (step_live_r) begin
          dash_phase_r <= dash_nxt;
          if (at_end_r) begin
            active_r <= 1'b0;
          end else begin
            err_r <= err_nxt;
            if (mv_x) begin
              cur_x_r <= step_x_neg_r ? cur_x_r - COORD_BITS'(1) : cur_x_r + COORD_BITS'(1);
            end
            if (mv_y) begin
              cur_y_r <= step_y_neg_r ? cur_y_r - COORD_BITS'(1) : cur_y_r + COORD_BITS'(1);
            end
          end
        end
      end else begin
        step_live_r <= step_live_r;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.begin_step) begin
      if (!active_r) begin
        out_x_r    <= '0;
        out_y_r    <= '0;
        out_ink_r  <= '0;
        out_we_r   <= 1'b0;
        out_last_r <= 1'b1;
        out_done_r <= 1'b1;
      end else if (draw) begin
        out_x_r    <= {1'b0, cur_x_r};
        out_y_r    <= {1'b0, cur_y_r};
        out_ink_r  <= line_ink_r;
        out_we_r   <= 1'b1;
        out_last_r <= (pen_m1_r == '0);
        out_done_r <= (pen_m1_r == '0) && at_end;
      end else begin
        // skipped dash point
        out_x_r    <= {1'b0, cur_x_r};
        out_y_r    <= {1'b0, cur_y_r};
        out_ink_r  <= line_ink_r;
        out_we_r   <= 1'b0;
        out_last_r <= 1'b1;
        out_done_r <= at_end;
      end
    end else if (cmd.next_pix) begin
      out_x_r    <= {1'b0, cur_x_r} + PIX_W'(dx_nxt);
      out_y_r    <= {1'b0, cur_y_r} + PIX_W'(dy_nxt);
      out_last_r <= last_nxt;
      out_done_r <= last_nxt && at_end_r;
    end
  end

  assign pixel_x         = out_x_r;
  assign pixel_y         = out_y_r;
  assign pixel_ink       = out_ink_r;
  assign write_enable    = out_we_r;
  assign pix_last        = out_last_r;
  assign line_done       = out_done_r;
  assign status.pix_last = out_last_r;

endmodule

// ----- hw/rtl/dashed_thick_line_rasterizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dashed_thick_line_rasterizer
// Bresenham line generator with square pen and optional dash pattern.
// ----------------------------------------------------------------------------
// Input stream: in_tuser selects the request. A start transaction loads the
// endpoints, ink, pen size and dash style and produces no result.
// A step transaction emits the pixel writes of the current line point
// and then advances the point one Bresenham step.
// Result stream: one transaction per pixel write, pen rows top to bottom,
// x fastest; tlast marks the final result of a step, out_tuser carries the
// write flag and the line-done flag. A skipped dash point or a step with no
// line loaded gives a single result with the write flag low.
// Latency: the first result is valid in the cycle after the step is taken.
// Throughput: one result per cycle while the receiver is ready; a drawn step
// gives one result per pen square pixel, walked by the pen walk counter.
// A step is worked on alone: in_tready is low until its last result is taken.
// A stalled receiver simply holds the current result and the walk.
// Reset leaves no line loaded, pen size one, solid style.
// ----------------------------------------------------------------------------
module dashed_thick_line_rasterizer #(
  parameter int COORD_BITS = dtlr_pkg::COORD_BITS_DEF,
  parameter int MAX_PEN    = dtlr_pkg::MAX_PEN_DEF,
  parameter int IN_W       = ((4 * COORD_BITS + 7 + 7) / 8) * 8,
  parameter int OUT_W      = ((2 * (COORD_BITS + 1) + 2 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // start_x, start_y, end_x, end_y, ink, pen_size, dashed, zero pad
  input  logic [IN_W-1:0]  in_tdata,
  // req_type
  input  logic [0:0]       in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  // pixel_x, pixel_y, pixel_ink, zero pad
  output logic [OUT_W-1:0] out_tdata,
  // write_enable, line_done
  output logic [1:0]       out_tuser,
  output logic             out_tlast
);
  import dtlr_pkg::*;

  localparam int CB = COORD_BITS;

  cmd_t    cmd;
  status_t status;

  logic [CB:0] pixel_x, pixel_y;
  logic [1:0]  pixel_ink;
  logic        write_enable, pix_last, line_done;

  dtlr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .req_type   (in_tuser[0]),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  dtlr_datapath #(
    .COORD_BITS (COORD_BITS),
    .MAX_PEN    (MAX_PEN)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .start_x      (in_tdata[CB-1:0]),
    .start_y      (in_tdata[2*CB-1:CB]),
    .end_x        (in_tdata[3*CB-1:2*CB]),
    .end_y        (in_tdata[4*CB-1:3*CB]),
    .ink          (in_tdata[4*CB+1:4*CB]),
    .pen_size     (in_tdata[4*CB+5:4*CB+2]),
    .dashed       (in_tdata[4*CB+6]),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .pixel_ink    (pixel_ink),
    .write_enable (write_enable),
    .pix_last     (pix_last),
    .line_done    (line_done)
  );

  assign out_tdata = OUT_W'({pixel_ink, pixel_y, pixel_x});
  assign out_tuser = {line_done, write_enable};
  assign out_tlast = pix_last;

endmodule

// ----- hw/rtl/dtlr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtlr_checker
// Port-level checks for the rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module dtlr_checker #(
  parameter int OUT_W = 32
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic [0:0]       in_tuser,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic [1:0]       out_tuser,
  input logic             out_tlast
);
  import dtlr_pkg::*;

  // one step at a time: never taking input while results are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a result is pending");

  // a step transaction always yields a result in the next cycle
  a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser[0] == REQ_STEP)) |=> out_tvalid)
    else $error("step transaction gave no result");

  // a start transaction yields nothing
  a_start_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser[0] == REQ_START)) |=> (in_tready && !out_tvalid))
    else $error("start transaction gave a result");

  // line done only on the last result of a step
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> out_tlast)
    else $error("line done without tlast");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast)))
    else $error("stalled result changed");

endmodule

bind dashed_thick_line_rasterizer dtlr_checker #(
  .OUT_W (OUT_W)
) u_dtlr_checker (.*);
